// ===== rtl/control_batch_send_window_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Batch send window assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef CONTROL_BATCH_SEND_WINDOW_UNIT_MACROS_SVH
`define CONTROL_BATCH_SEND_WINDOW_UNIT_MACROS_SVH

// same-cycle implication
`define CBSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbsw_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsw_pkg
// Types, codes and constants of the batch send window.
// ----------------------------------------------------------------------------
package cbsw_pkg;

  localparam int RECORD_QUEUE_DEPTH = 256;
  localparam int IN_FLIGHT_DEPTH    = 8;
  localparam int BATCH_RECORD_LIMIT = 32;

  // byte estimate weights
  localparam int EST_BASE       = 1024;
  localparam int EST_PER_REC    = 64;
  localparam int EST_PER_ORD    = 4;
  localparam int EST_PER_SETTLE = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDINALS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SETTLES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE    = 3'd4;

  localparam logic [3:0]  RST_MAX_IN_FLIGHT = 4'd4;
  localparam logic [5:0]  RST_MAX_RECORDS   = 6'd32;
  localparam logic [11:0] RST_MAX_ORDINALS  = 12'd1024;
  localparam logic [9:0]  RST_MAX_SETTLES   = 10'd256;
  localparam logic [6:0]  RST_CHUNK_SIZE    = 7'd64;

  localparam logic [2:0] F_ENQ    = 3'd0;
  localparam logic [2:0] F_SETTLE = 3'd1;
  localparam logic [2:0] F_BUILD  = 3'd2;
  localparam logic [2:0] F_ACK    = 3'd3;
  localparam logic [2:0] F_EST    = 3'd4;
  localparam logic [2:0] F_CLEAR  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOBATCH  = 3'd3;
  localparam logic [2:0] ST_ACKUNKWN = 3'd4;

  typedef struct packed {
    logic [15:0] tag;
    logic [11:0] offset;
    logic [6:0]  count;
    logic        cancel;
  } cbsw_rec_t;

  typedef struct packed {
    logic       capture;
    logic       emul;
    logic       ewrite;
    logic       ecommit;
    logic       exec;
    logic       plan_init;
    logic       plan_acc;
    logic       plan_end;
    logic       build_commit;
    logic       emit_load;
    logic       emit_commit;
    logic       resp_load;
    logic       st_we;
    logic [2:0] st_code;
  } cbsw_cmd_t;

  typedef struct packed {
    logic [2:0] in_func;
    logic [2:0] func;
    logic       ent_bad;
    logic       ent_full;
    logic       ent_last;
    logic       win_full;
    logic       plan_more;
    logic       plan_stop;
    logic       nothing;
    logic       nrec_zero;
    logic       emit_last;
    logic       out_free;
  } cbsw_sts_t;

endpackage

// ===== rtl/cbsw_if.sv =====
// ----------------------------------------------------------------------------
// cbsw channel interfaces
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface cbsw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] tag_in;
  logic        tag_valid;
  logic [11:0] ordinal_total;
  logic        cancel_in;
  logic [11:0] settlement_add;
  logic [31:0] ack_sequence;

  modport source (output valid, func, tag_in, tag_valid, ordinal_total, cancel_in,
                  settlement_add, ack_sequence, input ready);
  modport sink (input valid, func, tag_in, tag_valid, ordinal_total, cancel_in,
                settlement_add, ack_sequence, output ready);
endinterface

interface cbsw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        record_valid;
  logic [15:0] tag_out;
  logic [11:0] chunk_offset;
  logic [6:0]  chunk_count;
  logic        cancel_out;
  logic [31:0] sequence_res;
  logic [15:0] settlement_start;
  logic [9:0]  settlement_take;
  logic [15:0] estimated_bytes;
  logic        last;

  modport source (output valid, status, record_valid, tag_out, chunk_offset, chunk_count,
                  cancel_out, sequence_res, settlement_start, settlement_take,
                  estimated_bytes, last, input ready);
  modport sink (input valid, status, record_valid, tag_out, chunk_offset, chunk_count,
                cancel_out, sequence_res, settlement_start, settlement_take,
                estimated_bytes, last, output ready);
endinterface

// ===== rtl/cbsw_ram.sv =====
// ----------------------------------------------------------------------------
// cbsw_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbsw_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cbsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbsw_ctrl
// Operation sequencer: enqueue split, batch planning and record emission.
// ----------------------------------------------------------------------------
module cbsw_ctrl import cbsw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cbsw_sts_t sts,
  output cbsw_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EMUL = 4'd1;
  localparam logic [3:0] S_EDEC = 4'd2;
  localparam logic [3:0] S_EWR  = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_WCHK = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PCHK = 4'd7;
  localparam logic [3:0] S_PFIN = 4'd8;
  localparam logic [3:0] S_PDEC = 4'd9;
  localparam logic [3:0] S_ERD  = 4'd10;
  localparam logic [3:0] S_EOUT = 4'd11;
  localparam logic [3:0] S_RESP = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
          if (sts.in_func == F_ENQ) begin
            state_nxt = S_EMUL;
          end else if (sts.in_func == F_BUILD || sts.in_func == F_EST) begin
            state_nxt = S_WCHK;
          end
        end
      end
      S_EMUL: begin
        cmd.emul  = 1'b1;
        state_nxt = S_EDEC;
      end
      S_EDEC: begin
        if (sts.ent_bad) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_IGNORED;
          state_nxt   = S_RESP;
        end else if (sts.ent_full) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_FULL;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_EWR;
        end
      end
      S_EWR: begin
        cmd.ewrite = 1'b1;
        if (sts.ent_last) begin
          cmd.ecommit = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_WCHK: begin
        if (sts.win_full) begin
          // estimate reports zero bytes with status ok
          if (sts.func == F_BUILD) begin
            cmd.st_we   = 1'b1;
            cmd.st_code = ST_NOBATCH;
          end
          state_nxt = S_RESP;
        end else begin
          cmd.plan_init = 1'b1;
          state_nxt     = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = sts.plan_more ? S_PCHK : S_PFIN;
      end
      S_PCHK: begin
        if (sts.plan_stop) begin
          state_nxt = S_PFIN;
        end else begin
          cmd.plan_acc = 1'b1;
          state_nxt    = S_PRD;
        end
      end
      S_PFIN: begin
        cmd.plan_end = 1'b1;
        state_nxt    = (sts.func == F_EST) ? S_RESP : S_PDEC;
      end
      S_PDEC: begin
        if (sts.nothing) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_NOBATCH;
          state_nxt   = S_RESP;
        end else begin
          cmd.build_commit = 1'b1;
          state_nxt        = sts.nrec_zero ? S_RESP : S_ERD;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.emit_commit = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/cbsw_dp.sv =====
// ----------------------------------------------------------------------------
// cbsw_dp
// Record queue, settlement counters, in-flight window and result register.
// ----------------------------------------------------------------------------
module cbsw_dp import cbsw_pkg::*; #(
  parameter int RQ_DEPTH  = RECORD_QUEUE_DEPTH,
  parameter int IF_DEPTH  = IN_FLIGHT_DEPTH,
  parameter int REC_LIMIT = BATCH_RECORD_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cbsw_in_if.sink               in_ch,
  cbsw_out_if.source            out_ch,
  input  cbsw_cmd_t             cmd,
  output cbsw_sts_t             sts
);

  localparam int AW   = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int FW   = $clog2(RQ_DEPTH + 1);
  localparam int PW   = FW + 7;
  localparam int SW   = (IF_DEPTH > 1) ? $clog2(IF_DEPTH) : 1;
  localparam int CW   = $clog2(IF_DEPTH + 1);
  localparam int LW   = (CW > 4) ? CW : 4;
  localparam int NW   = $clog2(REC_LIMIT + 1);
  localparam int RW   = (NW > 6) ? NW : 6;
  localparam int XW   = (FW > NW) ? FW : NW;
  localparam int OW   = $clog2(REC_LIMIT * 127 + 1);
  localparam int PSW  = (OW + 1 > 13) ? OW + 1 : 13;
  localparam int EW0  = $clog2(EST_BASE + REC_LIMIT * EST_PER_REC
                               + REC_LIMIT * 127 * EST_PER_ORD + 1023 * EST_PER_SETTLE + 1);
  localparam int EW   = (EW0 > 17) ? EW0 : 17;
  localparam int QW   = $bits(cbsw_rec_t);

  function automatic logic [AW-1:0] qwrap(input logic [AW:0] s);
    qwrap = (s >= (AW+1)'(RQ_DEPTH)) ? AW'(s - (AW+1)'(RQ_DEPTH)) : AW'(s);
  endfunction

  // configuration
  logic [3:0]  mif_r;
  logic [5:0]  mrec_r;
  logic [11:0] mord_r;
  logic [9:0]  mset_r;
  logic [6:0]  mopr_r;

  // captured operation
  logic [2:0]  func_r;
  logic [15:0] tag_r;
  logic        tvld_r;
  logic [11:0] total_r;
  logic        cancel_r;
  logic [11:0] sadd_r;
  logic [31:0] ack_r;

  // queue and enqueue walk
  logic [AW-1:0] head_r, tail_r;
  logic [FW-1:0] fill_r, ecnt_r;
  logic [PW-1:0] prod_r;
  logic [11:0]   rem_r, off_r;

  logic [15:0] pend_r, sidx_r;
  logic [31:0] fseq_r [IF_DEPTH];
  logic [IF_DEPTH-1:0] fvld_r;
  logic [31:0] nseq_r;

  // planning
  logic [NW-1:0] idx_r, nrec_r;
  logic [OW-1:0] sum_r;
  logic [9:0]    take_r;

  // pending result
  logic [2:0]  res_st_r;
  logic [31:0] res_seq_r;
  logic [15:0] res_start_r;
  logic [9:0]  res_take_r;
  logic [15:0] res_est_r;

  // output register
  logic        ov_r;
  logic [2:0]  o_st_r;
  logic        o_rv_r;
  cbsw_rec_t   o_rec_r;
  logic [31:0] o_seq_r;
  logic [15:0] o_start_r;
  logic [9:0]  o_take_r;
  logic [15:0] o_est_r;
  logic        o_last_r;

  // combinational helpers
  cbsw_rec_t     rd_rec, wr_rec;
  logic [QW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [FW-1:0] free_c;
  logic [RW-1:0] rlim_c;
  logic [LW-1:0] fcnt_c, flim_c;
  logic [9:0]    take_c;
  logic [EW-1:0] est_c;
  logic [15:0]   est_sat;
  logic [SW-1:0] slot_c;
  logic [IF_DEPTH-1:0] hit_c;
  logic [16:0]   ssum_c;
  logic [2:0]    exec_st;
  logic          out_free;

  assign raddr  = qwrap((AW+1)'(head_r) + (AW+1)'(idx_r));
  assign rd_rec = cbsw_rec_t'(rdata);
  assign free_c = FW'(RQ_DEPTH) - fill_r;
  assign rlim_c = (RW'(mrec_r) < RW'(REC_LIMIT)) ? RW'(mrec_r) : RW'(REC_LIMIT);
  assign fcnt_c = LW'($countones(fvld_r));
  assign flim_c = (LW'(mif_r) < LW'(IF_DEPTH)) ? LW'(mif_r) : LW'(IF_DEPTH);
  assign take_c = (pend_r < 16'(mset_r)) ? 10'(pend_r) : mset_r;
  assign est_c  = EW'(EST_BASE) + EW'(idx_r) * EW'(EST_PER_REC)
                + EW'(sum_r) * EW'(EST_PER_ORD) + EW'(take_c) * EW'(EST_PER_SETTLE);
  assign est_sat = (est_c > EW'(16'hFFFF)) ? 16'hFFFF : 16'(est_c);
  assign ssum_c = 17'(pend_r) + 17'(sadd_r);
  assign out_free = !ov_r || out_ch.ready;

  assign wr_rec.tag    = tag_r;
  assign wr_rec.offset = off_r;
  assign wr_rec.count  = (rem_r < 12'(mopr_r)) ? 7'(rem_r) : mopr_r;
  assign wr_rec.cancel = cancel_r;

  always_comb begin
    slot_c = '0;
    for (int i = IF_DEPTH - 1; i >= 0; i--) begin
      if (!fvld_r[i]) begin
        slot_c = SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < IF_DEPTH; i++) begin
      hit_c[i] = fvld_r[i] && (fseq_r[i] == ack_r) && (ack_r != 32'd0);
    end
  end

  always_comb begin
    unique case (func_r)
      F_SETTLE: exec_st = ssum_c[16] ? ST_FULL : ST_OK;
      F_ACK:    exec_st = (|hit_c) ? ST_OK : ST_ACKUNKWN;
      F_CLEAR:  exec_st = ST_OK;
      default:  exec_st = ST_IGNORED;
    endcase
  end

  assign sts.in_func   = in_ch.func;
  assign sts.func      = func_r;
  assign sts.ent_bad   = !tvld_r || (total_r == 12'd0) || (mopr_r == 7'd0);
  assign sts.ent_full  = PW'(total_r) > prod_r;
  assign sts.ent_last  = rem_r <= 12'(mopr_r);
  assign sts.win_full  = fcnt_c >= flim_c;
  assign sts.plan_more = (XW'(idx_r) < XW'(fill_r)) && (RW'(idx_r) < rlim_c);
  assign sts.plan_stop = (idx_r != '0)
                      && (PSW'(sum_r) + PSW'(rd_rec.count) > PSW'(mord_r));
  assign sts.nothing   = (nrec_r == '0) && (take_r == 10'd0);
  assign sts.nrec_zero = (nrec_r == '0);
  assign sts.emit_last = ((NW+1)'(idx_r) + (NW+1)'(1)) == (NW+1)'(nrec_r);
  assign sts.out_free  = out_free;

  cbsw_ram #(.WIDTH(QW), .DEPTH(RQ_DEPTH)) u_queue (
    .clk   (clk),
    .we    (cmd.ewrite),
    .waddr (tail_r),
    .wdata (wr_rec),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mif_r  <= RST_MAX_IN_FLIGHT;
      mrec_r <= RST_MAX_RECORDS;
      mord_r <= RST_MAX_ORDINALS;
      mset_r <= RST_MAX_SETTLES;
      mopr_r <= RST_CHUNK_SIZE;
      head_r <= '0;
      fill_r <= '0;
      pend_r <= '0;
      sidx_r <= '0;
      fvld_r <= '0;
      nseq_r <= 32'd1;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MAX_IN_FLIGHT: mif_r  <= cfg_wdata[3:0];
          CFG_MAX_RECORDS:   mrec_r <= cfg_wdata[5:0];
          CFG_MAX_ORDINALS:  mord_r <= cfg_wdata[11:0];
          CFG_MAX_SETTLES:   mset_r <= cfg_wdata[9:0];
          CFG_CHUNK_SIZE:    mopr_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (cmd.ecommit) begin
        fill_r <= fill_r + ecnt_r + FW'(1);
      end
      if (cmd.exec) begin
        if (func_r == F_SETTLE && !ssum_c[16]) begin
          pend_r <= ssum_c[15:0];
        end
        if (func_r == F_ACK) begin
          fvld_r <= fvld_r & ~hit_c;
        end
        if (func_r == F_CLEAR) begin
          head_r <= '0;
          fill_r <= '0;
          pend_r <= '0;
          sidx_r <= '0;
          fvld_r <= '0;
          nseq_r <= 32'd1;
        end
      end
      if (cmd.build_commit) begin
        fvld_r[slot_c] <= 1'b1;
        nseq_r         <= (nseq_r == 32'hFFFF_FFFF) ? 32'd1 : nseq_r + 32'd1;
        sidx_r         <= sidx_r + 16'(take_r);
        pend_r         <= pend_r - 16'(take_r);
      end
      if (cmd.emit_commit) begin
        head_r <= qwrap((AW+1)'(head_r) + (AW+1)'(nrec_r));
        fill_r <= fill_r - FW'(nrec_r);
      end
      if (cmd.emit_load || cmd.resp_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r      <= in_ch.func;
      tag_r       <= in_ch.tag_in;
      tvld_r      <= in_ch.tag_valid;
      total_r     <= in_ch.ordinal_total;
      cancel_r    <= in_ch.cancel_in;
      sadd_r      <= in_ch.settlement_add;
      ack_r       <= in_ch.ack_sequence;
      res_st_r    <= ST_OK;
      res_seq_r   <= '0;
      res_start_r <= '0;
      res_take_r  <= '0;
      res_est_r   <= '0;
    end
    if (cmd.emul) begin
      prod_r <= PW'(free_c) * PW'(mopr_r);
      tail_r <= qwrap((AW+1)'(head_r) + (AW+1)'(fill_r));
      rem_r  <= total_r;
      off_r  <= '0;
      ecnt_r <= '0;
    end
    if (cmd.ewrite) begin
      tail_r <= qwrap((AW+1)'(tail_r) + (AW+1)'(1));
      rem_r  <= rem_r - 12'(mopr_r);
      off_r  <= off_r + 12'(mopr_r);
      ecnt_r <= ecnt_r + FW'(1);
    end
    if (cmd.exec) begin
      res_st_r <= exec_st;
    end
    if (cmd.st_we) begin
      res_st_r <= cmd.st_code;
    end
    if (cmd.plan_init) begin
      idx_r <= '0;
      sum_r <= '0;
    end
    if (cmd.plan_acc) begin
      idx_r <= idx_r + NW'(1);
      sum_r <= sum_r + OW'(rd_rec.count);
    end
    if (cmd.plan_end) begin
      nrec_r <= idx_r;
      take_r <= take_c;
      if (func_r == F_EST) begin
        res_est_r <= ((idx_r != '0) || (take_c != 10'd0)) ? est_sat : 16'd0;
      end
    end
    if (cmd.build_commit) begin
      fseq_r[slot_c] <= nseq_r;
      res_seq_r      <= nseq_r;
      res_start_r    <= sidx_r;
      res_take_r     <= take_r;
      idx_r          <= '0;
    end
    if (cmd.emit_load) begin
      o_st_r    <= ST_OK;
      o_rv_r    <= 1'b1;
      o_rec_r   <= rd_rec;
      o_seq_r   <= res_seq_r;
      o_start_r <= res_start_r;
      o_take_r  <= res_take_r;
      o_est_r   <= '0;
      o_last_r  <= sts.emit_last;
      idx_r     <= idx_r + NW'(1);
    end
    if (cmd.resp_load) begin
      o_st_r    <= res_st_r;
      o_rv_r    <= 1'b0;
      o_rec_r   <= '0;
      o_seq_r   <= res_seq_r;
      o_start_r <= res_start_r;
      o_take_r  <= res_take_r;
      o_est_r   <= res_est_r;
      o_last_r  <= 1'b1;
    end
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.status           = o_st_r;
  assign out_ch.record_valid     = o_rv_r;
  assign out_ch.tag_out          = o_rec_r.tag;
  assign out_ch.chunk_offset     = o_rec_r.offset;
  assign out_ch.chunk_count      = o_rec_r.count;
  assign out_ch.cancel_out       = o_rec_r.cancel;
  assign out_ch.sequence_res     = o_seq_r;
  assign out_ch.settlement_start = o_start_r;
  assign out_ch.settlement_take  = o_take_r;
  assign out_ch.estimated_bytes  = o_est_r;
  assign out_ch.last             = o_last_r;

endmodule

// ===== rtl/control_batch_send_window_unit.sv =====
// ----------------------------------------------------------------------------
// control_batch_send_window_unit
// One operation at a time; ack, settle, clear: S_EXEC, then the result beat.
// Enqueue: S_EMUL, S_EDEC, then one S_EWR per chunk written to the queue RAM.
// Build/estimate: S_PRD read, S_PCHK check per planned record; S_ERD read,
// S_EOUT load per emitted beat (set by the registered queue read port).
// Synchronous active-low reset; queue contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
`include "control_batch_send_window_unit_macros.svh"

module control_batch_send_window_unit import cbsw_pkg::*; #(
  parameter int RQ_DEPTH  = RECORD_QUEUE_DEPTH,
  parameter int IF_DEPTH  = IN_FLIGHT_DEPTH,
  parameter int REC_LIMIT = BATCH_RECORD_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cbsw_in_if.sink               in_ch,
  cbsw_out_if.source            out_ch
);

  cbsw_cmd_t cmd;
  cbsw_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  cbsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbsw_dp #(
    .RQ_DEPTH  (RQ_DEPTH),
    .IF_DEPTH  (IF_DEPTH),
    .REC_LIMIT (REC_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

  `CBSW_ASSERT_NXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after take")
  `CBSW_ASSERT_IMP(a_emit_free, cmd.emit_load, sts.out_free, "record beat overwrites result")
  `CBSW_ASSERT_IMP(a_resp_free, cmd.resp_load, sts.out_free, "result beat overwrites result")
  `CBSW_ASSERT_IMP(a_commit_last, cmd.emit_commit, cmd.emit_load && sts.emit_last, "early commit")

endmodule
